// ===== sv/ftvp_pkg.sv =====
// shared constants and types for the fix tag=value field parser
package ftvp_pkg;

    localparam int MSG_BYTES = 4096;
    localparam int POS_W = $clog2(MSG_BYTES + 1);

    localparam int BYTE_W = 8;
    localparam int TAG_W = 32;
    localparam int OFF_W = 13;
    localparam int LEN_W = 12;
    localparam int DIGIT_W = 4;
    localparam int MUL_W = TAG_W + DIGIT_W;

    localparam logic [BYTE_W-1:0] EQUALS_CHAR = 8'h3D;
    localparam logic [BYTE_W-1:0] DELIM_RESET = 8'h01;
    localparam logic [BYTE_W-1:0] DIGIT_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] DIGIT_NINE = 8'h39;

    typedef struct packed {
        logic             is_digit;
        logic             overflow;
        logic [TAG_W-1:0] value;
    } tag_step_t;

    typedef struct packed {
        logic             field_valid;
        logic [TAG_W-1:0] field_tag;
        logic [OFF_W-1:0] value_offset;
        logic [LEN_W-1:0] value_length;
        logic             message_end;
        logic             message_too_long;
    } result_t;

    typedef struct packed {
        logic             equals_seen;
        logic [POS_W-1:0] equals_pos;
        logic [TAG_W-1:0] tag_acc;
        logic             tag_invalid;
        logic             tag_digit;
    } segment_t;

endpackage

// ===== sv/ftvp_ifs.sv =====
// handshake channel interfaces for message bytes, parsed fields and configuration
interface ftvp_byte_if
    import ftvp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface ftvp_field_if
    import ftvp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             field_valid;
    logic [TAG_W-1:0] field_tag;
    logic [OFF_W-1:0] value_offset;
    logic [LEN_W-1:0] value_length;
    logic             message_end;
    logic             message_too_long;

    modport source (
        output valid, field_valid, field_tag, value_offset, value_length,
               message_end, message_too_long,
        input  ready
    );
    modport sink (
        input  valid, field_valid, field_tag, value_offset, value_length,
               message_end, message_too_long,
        output ready
    );
endinterface

interface ftvp_cfg_if
    import ftvp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] delimiter_byte;

    modport source (output valid, delimiter_byte, input ready);
    modport sink (input valid, delimiter_byte, output ready);
endinterface

// ===== sv/ftvp_tag_acc.sv =====
// decimal tag digit step: times ten plus digit with 32-bit overflow detect
module ftvp_tag_acc
    import ftvp_pkg::*;
(
    input  logic [TAG_W-1:0]  acc,
    input  logic [BYTE_W-1:0] data_byte,
    output tag_step_t         step
);

    logic [BYTE_W-1:0]  digit_full;
    logic [DIGIT_W-1:0] digit;
    logic [MUL_W-1:0]   acc_ext;
    logic [MUL_W-1:0]   sum;

    assign digit_full = data_byte - DIGIT_ZERO;
    assign digit = digit_full[DIGIT_W-1:0];
    assign acc_ext = {{DIGIT_W{1'b0}}, acc};

    // acc * 10 as shift-and-add
    assign sum = (acc_ext << 3) + (acc_ext << 1) + {{TAG_W{1'b0}}, digit};

    assign step.is_digit = (data_byte >= DIGIT_ZERO) && (data_byte <= DIGIT_NINE);
    assign step.overflow = |sum[MUL_W-1:TAG_W];
    assign step.value = sum[TAG_W-1:0];

endmodule

// ===== sv/fix_tag_value_field_parser.sv =====
// fix tag=value field parser top level: byte stream in, parsed fields out
// result path: a byte transaction is registered in the input register, its result in the result register
// throughput: one byte per cycle unless a held result stalls it, limited by the single-pass segment logic
// a byte with no field and no message end consumes its cycle and gives no result
// reset: all control and segment state cleared, delimiter back to 0x01
module fix_tag_value_field_parser
    import ftvp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ftvp_byte_if.sink    msg,
    ftvp_field_if.source field,
    ftvp_cfg_if.sink     cfg
);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] in_data_reg;
    logic              in_last_reg;

    logic [BYTE_W-1:0] delim_reg;
    logic [POS_W-1:0]  byte_pos_reg;
    logic [POS_W-1:0]  byte_pos_next;
    logic              len_exc_reg;
    logic              len_exc_next;
    segment_t          seg_reg;
    segment_t          seg_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_res_reg;
    result_t           res;

    logic              msg_accept;
    logic              process;
    logic              produce;
    logic              exceed;
    logic              len_exc_now;
    logic              is_delim;
    logic              is_eq;
    segment_t          seg_after;
    segment_t          seg_clear;
    tag_step_t         tag_step;
    logic              fv;
    logic [POS_W:0]    end_pos;
    logic [POS_W:0]    start_pos;
    logic [POS_W:0]    len_full;

    ftvp_tag_acc u_tag_acc (
        .acc       (seg_reg.tag_acc),
        .data_byte (in_data_reg),
        .step      (tag_step)
    );

    assign cfg.ready = 1'b1;

    assign process = in_valid_reg && (!out_valid_reg || field.ready);
    assign msg.ready = !in_valid_reg || process;
    assign msg_accept = msg.valid && msg.ready;
    assign in_valid_next = msg_accept ? 1'b1 : (process ? 1'b0 : in_valid_reg);

    assign exceed = byte_pos_reg >= POS_W'(MSG_BYTES);
    assign len_exc_now = len_exc_reg || exceed;
    assign is_delim = in_data_reg == delim_reg;
    assign is_eq = in_data_reg == EQUALS_CHAR;

    assign seg_clear = '0;

    // segment state after a non-delimiter byte
    always_comb
    begin
        seg_after = seg_reg;
        if (!is_delim && !seg_reg.equals_seen)
        begin
            if (is_eq)
            begin
                seg_after.equals_seen = 1'b1;
                seg_after.equals_pos = byte_pos_reg;
            end
            else if (!seg_reg.tag_invalid)
            begin
                if (tag_step.is_digit)
                begin
                    seg_after.tag_digit = 1'b1;
                    if (tag_step.overflow)
                    begin
                        seg_after.tag_invalid = 1'b1;
                    end
                    else
                    begin
                        seg_after.tag_acc = tag_step.value;
                    end
                end
                else
                begin
                    seg_after.tag_invalid = 1'b1;
                end
            end
        end
    end

    // field completes at a delimiter, or is flushed at message end
    assign fv = (is_delim || in_last_reg) && seg_after.equals_seen && seg_after.tag_digit
                && !seg_after.tag_invalid && !len_exc_now;
    assign produce = fv || in_last_reg;

    assign end_pos = {1'b0, byte_pos_reg} + {{POS_W{1'b0}}, !is_delim};
    assign start_pos = {1'b0, seg_after.equals_pos} + {{POS_W{1'b0}}, 1'b1};
    assign len_full = end_pos - start_pos;

    always_comb
    begin
        res = '0;
        res.message_end = in_last_reg;
        res.message_too_long = in_last_reg && len_exc_now;
        if (fv)
        begin
            res.field_valid = 1'b1;
            res.field_tag = seg_after.tag_acc;
            res.value_offset = OFF_W'(start_pos);
            res.value_length = LEN_W'(len_full);
        end
    end

    always_comb
    begin
        byte_pos_next = byte_pos_reg;
        len_exc_next = len_exc_reg;
        seg_next = seg_reg;
        if (process)
        begin
            if (in_last_reg)
            begin
                byte_pos_next = '0;
                len_exc_next = 1'b0;
                seg_next = seg_clear;
            end
            else
            begin
                byte_pos_next = exceed ? POS_W'(MSG_BYTES) : byte_pos_reg + POS_W'(1);
                len_exc_next = len_exc_now;
                seg_next = is_delim ? seg_clear : seg_after;
            end
        end
    end

    assign out_valid_next = (process && produce) ? 1'b1 :
                            (field.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            delim_reg <= DELIM_RESET;
            byte_pos_reg <= '0;
            len_exc_reg <= 1'b0;
            seg_reg <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
            byte_pos_reg <= byte_pos_next;
            len_exc_reg <= len_exc_next;
            seg_reg <= seg_next;
            if (cfg.valid && cfg.ready)
            begin
                delim_reg <= cfg.delimiter_byte;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (msg_accept)
        begin
            in_data_reg <= msg.data_byte;
            in_last_reg <= msg.last_byte;
        end
        if (process && produce)
        begin
            out_res_reg <= res;
        end
    end

    assign field.valid = out_valid_reg;
    assign field.field_valid = out_res_reg.field_valid;
    assign field.field_tag = out_res_reg.field_tag;
    assign field.value_offset = out_res_reg.value_offset;
    assign field.value_length = out_res_reg.value_length;
    assign field.message_end = out_res_reg.message_end;
    assign field.message_too_long = out_res_reg.message_too_long;

    // message end returns to start-of-message state
    a_msg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        process && in_last_reg |=> byte_pos_reg == '0 && !len_exc_reg && !seg_reg.equals_seen)
        else $error("state not cleared after message end");

    // byte position saturates at the message limit
    a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
        byte_pos_reg <= POS_W'(MSG_BYTES))
        else $error("byte position beyond message limit");

    // overlong condition sticks until message end
    a_len_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        process && exceed && !in_last_reg |=> len_exc_reg)
        else $error("length exceeded flag lost");

    // a byte that causes a result always finds room in the result register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        process && produce |-> !out_valid_reg || field.ready)
        else $error("result register overwritten");

endmodule

// ===== bench/tb_top.sv =====
// testbench for the fix tag=value field parser: directed and random byte streams checked against a field predictor
module tb_top;
    import ftvp_pkg::*;

    localparam int HALF_PERIOD = 2;
    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_BYTES = 160;
    localparam logic [BYTE_W-1:0] PIPE_CHAR = 8'h7C;
    localparam logic [BYTE_W-1:0] MAX_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

    logic clk = 1'b0;
    logic rst_n;

    ftvp_byte_if  msg();
    ftvp_field_if field();
    ftvp_cfg_if   cfg();

    fix_tag_value_field_parser u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg),
        .field (field),
        .cfg   (cfg)
    );

    // predictor state
    logic [BYTE_W-1:0] delim;
    int unsigned       msg_pos;
    bit                seg_eq;
    int unsigned       seg_eq_pos;
    logic [TAG_W-1:0]  seg_tag;
    bit                seg_bad;
    bit                seg_digit;
    bit                msg_long;

    result_t           expected_fields[$];
    logic [BYTE_W-1:0] msg_text[$];

    int unsigned error_count = 0;
    int unsigned bytes_accepted = 0;
    int unsigned idle_cycles = 0;
    bit          tx_idles = 1'b0;
    bit          rx_idles = 1'b0;
    bit          hold_request = 1'b0;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic void clear_segment();
        seg_eq = 1'b0;
        seg_eq_pos = 0;
        seg_tag = '0;
        seg_bad = 1'b0;
        seg_digit = 1'b0;
    endfunction

    function automatic bit close_segment(input int unsigned end_pos, inout result_t r);
        int unsigned start;
        bit ok;
        ok = seg_eq && seg_digit && !seg_bad && !msg_long;
        if (ok)
        begin
            start = seg_eq_pos + 1;
            r.field_valid = 1'b1;
            r.field_tag = seg_tag;
            r.value_offset = OFF_W'(start);
            r.value_length = LEN_W'((end_pos >= start) ? end_pos - start : 0);
        end
        clear_segment();
        return ok;
    endfunction

    // advances the parser state by one byte, returns 1 if a result is due
    function automatic bit parse_byte(input logic [BYTE_W-1:0] b, input logic last,
                                      output result_t r);
        int unsigned pos;
        bit emitted;
        logic [63:0] next;
        r = '0;
        emitted = 1'b0;
        pos = msg_pos;
        if (pos >= MSG_BYTES)
        begin
            msg_long = 1'b1;
            pos = MSG_BYTES;
        end
        if (b == delim)
            emitted = close_segment(pos, r);
        else if (!seg_eq)
        begin
            if (b == EQUALS_CHAR)
            begin
                seg_eq = 1'b1;
                seg_eq_pos = pos;
            end
            else if (!seg_bad)
            begin
                if (b >= DIGIT_ZERO && b <= DIGIT_NINE)
                begin
                    next = {32'b0, seg_tag} * 64'd10 + 64'(b - DIGIT_ZERO);
                    if (next > 64'hFFFF_FFFF)
                        seg_bad = 1'b1;
                    else
                        seg_tag = next[TAG_W-1:0];
                    seg_digit = 1'b1;
                end
                else
                    seg_bad = 1'b1;
            end
        end
        msg_pos = (pos < MSG_BYTES) ? pos + 1 : MSG_BYTES;
        if (last)
        begin
            if (!emitted && seg_eq)
                emitted = close_segment(pos + 1, r);
            r.message_end = 1'b1;
            r.message_too_long = msg_long;
            clear_segment();
            msg_pos = 0;
            msg_long = 1'b0;
            return 1'b1;
        end
        return emitted;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int unsigned gap;
        result_t r;
        gap = 0;
        if (tx_idles && $urandom_range(0, 99) < 25)
            gap = pick_gap();
        if (gap > 0)
        begin
            msg.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg.valid <= 1'b1;
        msg.data_byte <= b;
        msg.last_byte <= last;
        do
            @(posedge clk);
        while (!msg.ready);
        bytes_accepted++;
        if (parse_byte(b, last, r))
            expected_fields.insert(expected_fields.size(), r);
    endtask

    task automatic put_byte(input logic [BYTE_W-1:0] b);
        msg_text.insert(msg_text.size(), b);
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task automatic send_message();
        int i;
        for (i = 0; i < msg_text.size(); i++)
            send_byte(msg_text[i], i == msg_text.size() - 1);
        msg_text.delete();
    endtask

    // sends bytes without a final last flag, leaving the message open
    task automatic send_partial();
        int i;
        for (i = 0; i < msg_text.size(); i++)
            send_byte(msg_text[i], 1'b0);
        msg_text.delete();
    endtask

    task automatic drain();
        msg.valid <= 1'b0;
        while (expected_fields.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_set(input logic [BYTE_W-1:0] d);
        drain();
        cfg.valid <= 1'b1;
        cfg.delimiter_byte <= d;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        delim = d;
    endtask

    function automatic string tag_text();
        int unsigned r;
        longint unsigned v;
        string t;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $sformatf("%0d", $urandom_range(1, 999));
        if (r < 70)
            return $sformatf("%0d", $urandom_range(1000, 99999));
        if (r < 78)
            return $sformatf("%0d", $urandom());
        if (r < 86)
        begin
            case ($urandom_range(0, 2))
                0: v = 64'hFFFF_FFFF - $urandom_range(0, 3);
                1: v = 64'h1_0000_0000 + $urandom_range(0, 3);
                default: v = {$urandom(), $urandom()};
            endcase
            return $sformatf("%0d", v);
        end
        if (r < 90)
            return {"00", $sformatf("%0d", $urandom_range(0, 99))};
        if (r < 94)
            return "";
        t = $sformatf("%0d", $urandom_range(1, 999));
        t.putc($urandom_range(0, t.len() - 1), byte'($urandom_range(8'h61, 8'h7A)));
        return t;
    endfunction

    function automatic logic [BYTE_W-1:0] value_byte();
        logic [BYTE_W-1:0] b;
        if ($urandom_range(0, 9) == 0)
            return EQUALS_CHAR;
        b = BYTE_W'($urandom_range(0, 255));
        if (b == delim)
            b = b ^ 8'h5A;
        return b;
    endfunction

    // mostly well-formed field sequences, some noise and truncated messages
    task automatic build_random_message();
        int unsigned n;
        int unsigned vlen;
        int unsigned r;
        int i;
        int j;
        if ($urandom_range(0, 99) < 12)
        begin
            n = $urandom_range(1, 24);
            for (i = 0; i < n; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    put_byte(delim);
                else if (r < 35)
                    put_byte(EQUALS_CHAR);
                else if (r < 50)
                    put_byte(BYTE_W'(DIGIT_ZERO + $urandom_range(0, 9)));
                else
                    put_byte(BYTE_W'($urandom_range(0, 255)));
            end
        end
        else
        begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
            begin
                add_text(tag_text());
                if ($urandom_range(0, 99) < 92)
                begin
                    put_byte(EQUALS_CHAR);
                    vlen = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40)
                                                         : $urandom_range(0, 10);
                    for (j = 0; j < vlen; j++)
                        put_byte(value_byte());
                end
                put_byte(delim);
            end
            if ($urandom_range(0, 1) == 0 && msg_text.size() > 1)
                void'(msg_text.pop_back());
        end
    endtask

    task automatic test_field_forms();
        // max tag, second '=' and extreme bytes in the value, delimiter as last byte
        add_text("4294967295==");
        put_byte(MAX_BYTE);
        put_byte(ZERO_BYTE);
        put_byte(delim);
        send_message();
        // overflowed tag, empty tag, non-digit tag, no '=', then flush at message end
        add_text("4294967296=a");
        put_byte(delim);
        add_text("=b");
        put_byte(delim);
        add_text("1x=c");
        put_byte(delim);
        add_text("77");
        put_byte(delim);
        add_text("5=");
        send_message();
        add_text("7");
        send_message();
    endtask

    task automatic test_delimiter_register();
        // delimiter equal to '=' wins over the tag separator
        cfg_set(EQUALS_CHAR);
        add_text("12=34=5");
        send_message();
        // delimiter changed in the middle of a message
        cfg_set(PIPE_CHAR);
        add_text("9=ab|3=");
        send_partial();
        cfg_set(MAX_BYTE);
        add_text("x|");
        put_byte(MAX_BYTE);
        add_text("8");
        send_message();
        cfg_set(ZERO_BYTE);
        add_text("1=");
        put_byte(ZERO_BYTE);
        send_message();
    endtask

    task automatic test_length_limit();
        cfg_set(DELIM_RESET);
        // exactly MSG_BYTES long, last field flushed at the final position
        while (msg_text.size() < MSG_BYTES - 16)
        begin
            add_text("35=ABCDEFG");
            put_byte(delim);
        end
        add_text("10=");
        while (msg_text.size() < MSG_BYTES)
            put_byte(8'h78);
        send_message();
        // longer than the limit, delimiter right at the first position beyond it
        while (msg_text.size() < MSG_BYTES - 6)
        begin
            add_text("7=v");
            put_byte(delim);
        end
        add_text("9=");
        while (msg_text.size() < MSG_BYTES)
            put_byte(8'h79);
        put_byte(delim);
        add_text("4=z");
        put_byte(delim);
        send_message();
    endtask

    task automatic test_backpressure();
        int unsigned start;
        tx_idles = 1'b0;
        rx_idles = 1'b0;
        hold_request = 1'b1;
        start = bytes_accepted;
        while (bytes_accepted - start < 80)
        begin
            build_random_message();
            send_message();
        end
    endtask

    task automatic test_random_traffic();
        int p;
        int unsigned start;
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: cfg_set(DELIM_RESET);
                1: cfg_set(ZERO_BYTE);
                2: cfg_set(MAX_BYTE);
                3: cfg_set(EQUALS_CHAR);
                4: cfg_set(PIPE_CHAR);
                default: cfg_set(BYTE_W'($urandom_range(0, 255)));
            endcase
            tx_idles = (p != 2) && ($urandom_range(0, 3) != 0);
            rx_idles = (p != 2) && ($urandom_range(0, 3) != 0);
            start = bytes_accepted;
            while (bytes_accepted - start < PHASE_BYTES)
            begin
                build_random_message();
                send_message();
            end
        end
    endtask

    // result receiver with random stalls and one long hold-off on request
    initial
    begin
        int unsigned rx_gap;
        int unsigned hold_left;
        logic rdy;
        rx_gap = 0;
        hold_left = 0;
        field.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                rdy = 1'b0;
            end
            else
            begin
                rdy = 1'b1;
                if (rx_idles && $urandom_range(0, 99) < 20)
                    rx_gap = pick_gap();
            end
            field.ready <= rdy;
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && field.valid && field.ready)
        begin
            if (expected_fields.size() == 0)
                report_mismatch("result with none expected", 64'd0, 64'd0);
            else
            begin
                want = expected_fields.pop_front();
                if (field.field_valid !== want.field_valid)
                    report_mismatch("field_valid", 64'(field.field_valid),
                                    64'(want.field_valid));
                if (field.field_tag !== want.field_tag)
                    report_mismatch("field_tag", 64'(field.field_tag), 64'(want.field_tag));
                if (field.value_offset !== want.value_offset)
                    report_mismatch("value_offset", 64'(field.value_offset),
                                    64'(want.value_offset));
                if (field.value_length !== want.value_length)
                    report_mismatch("value_length", 64'(field.value_length),
                                    64'(want.value_length));
                if (field.message_end !== want.message_end)
                    report_mismatch("message_end", 64'(field.message_end),
                                    64'(want.message_end));
                if (field.message_too_long !== want.message_too_long)
                    report_mismatch("message_too_long", 64'(field.message_too_long),
                                    64'(want.message_too_long));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (msg.valid && msg.ready) || (field.valid && field.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        msg.valid <= 1'b0;
        msg.data_byte <= '0;
        msg.last_byte <= 1'b0;
        cfg.valid <= 1'b0;
        cfg.delimiter_byte <= '0;
        delim = DELIM_RESET;
        msg_pos = 0;
        msg_long = 1'b0;
        clear_segment();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        tx_idles = 1'b1;
        rx_idles = 1'b1;
        test_field_forms();
        test_delimiter_register();
        test_length_limit();
        test_backpressure();
        test_random_traffic();
        drain();
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ftvp_pkg.sv
sv/ftvp_ifs.sv
sv/ftvp_tag_acc.sv
sv/fix_tag_value_field_parser.sv
bench/tb_top.sv
